/* hw/rtl/fipa_pkg.sv */
`timescale 1ns / 1ps
package fipa_pkg;

	// Field widths of the request and response beats and of the configuration fields.
	localparam int OP_W   = 2;
	localparam int IDX_W  = 10;
	localparam int OFS_W  = 22;
	localparam int CNT_W  = 11;
	localparam int SIZE_W = 13;
	localparam int LOG_W  = 4;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Limits applied to the configuration registers, and the reset values.
	localparam logic [LOG_W-1:0]  ALIGN_LOG2_MIN = 4'd3;
	localparam logic [LOG_W-1:0]  ALIGN_LOG2_MAX = 4'd12;
	localparam logic [SIZE_W-1:0] ITEM_SIZE_MAX  = 13'd4096;
	localparam logic [SIZE_W-1:0] ITEM_SIZE_RST  = 13'd8;
	localparam logic [LOG_W-1:0]  ALIGN_LOG2_RST = 4'd3;
	localparam logic [SIZE_W-1:0] ALIGNED_RST    = 13'd8;

	// The live count saturates at its all-ones value.
	localparam logic [CNT_W-1:0] LIVE_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic {
		REG_ITEM_SIZE  = 1'b0,
		REG_ALIGN_LOG2 = 1'b1
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [SIZE_W-1:0] item_size;
		logic [LOG_W-1:0]  align_log2;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic commit;
	} cmd_t;

endpackage

/* hw/rtl/fipa_req_if.sv */
`timescale 1ns / 1ps
interface fipa_req_if import fipa_pkg::*;;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [IDX_W-1:0] free_index;

	modport source (output valid, output operation, output free_index, input ready);
	modport sink (input valid, input operation, input free_index, output ready);
endinterface

/* hw/rtl/fipa_rsp_if.sv */
`timescale 1ns / 1ps
interface fipa_rsp_if import fipa_pkg::*;;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] item_index;
	logic [OFS_W-1:0] byte_offset;
	logic             status;
	logic [CNT_W-1:0] live_count;
	logic [CNT_W-1:0] high_water;

	modport source (output valid, output item_index, output byte_offset, output status,
		output live_count, output high_water, input ready);
	modport sink (input valid, input item_index, input byte_offset, input status,
		input live_count, input high_water, output ready);
endinterface

/* hw/rtl/fipa_ram.sv */
`timescale 1ns / 1ps
module fipa_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/fipa_regs.sv */
`timescale 1ns / 1ps
module fipa_regs import fipa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.item_size  <= ITEM_SIZE_RST;
			cfg_q.align_log2 <= ALIGN_LOG2_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ITEM_SIZE:  cfg_q.item_size  <= pwdata[SIZE_W-1:0];
				REG_ALIGN_LOG2: cfg_q.align_log2 <= pwdata[LOG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ITEM_SIZE:  prdata = PDATA_W'(cfg_q.item_size);
			REG_ALIGN_LOG2: prdata = PDATA_W'(cfg_q.align_log2);
			default: ;
		endcase
	end

endmodule

/* hw/rtl/fipa_ctrl.sv */
`timescale 1ns / 1ps
module fipa_ctrl import fipa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result is written into the output slot only once the slot is free
	// or its beat leaves at the same edge.
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd.accept = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/fipa_dp.sv */
`timescale 1ns / 1ps
module fipa_dp import fipa_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  cfg_t             cfg,
	input  logic [OP_W-1:0]  operation,
	input  logic [IDX_W-1:0] free_index,
	output logic [IDX_W-1:0] item_index,
	output logic [OFS_W-1:0] byte_offset,
	output logic             status,
	output logic [CNT_W-1:0] live_count,
	output logic [CNT_W-1:0] high_water
);

	localparam int IW         = $clog2(CAPACITY);
	localparam int BW         = $clog2(CAPACITY + 1);
	localparam int LINK_DEPTH = (CAPACITY < (1 << IDX_W)) ? CAPACITY : (1 << IDX_W);
	localparam int AW         = $clog2(LINK_DEPTH);
	localparam int LINK_W     = IDX_W + 1;
	localparam int PW         = IW + SIZE_W;

	// Request latched at accept.
	op_t              op_q;
	logic [IDX_W-1:0] fi_q;

	// Pool state.
	logic [IDX_W-1:0] head_q, head_d;
	logic             nonempty_q, nonempty_d;
	logic [BW-1:0]    bump_q, bump_d;
	logic [CNT_W-1:0] live_q, live_d;

	// Result held for the response beat.
	logic [IDX_W-1:0] item_q;
	logic [OFS_W-1:0] offset_q;
	logic             status_q;

	logic [LOG_W-1:0]  lg;
	logic [SIZE_W-1:0] sz;
	logic [SIZE_W-1:0] mask;
	logic [SIZE_W:0]   round_sum;
	logic [SIZE_W-1:0] aligned_q;

	logic [IW-1:0]     idx;
	logic [PW-1:0]     prod;
	logic              got;
	logic              exhausted;
	logic              link_we;
	logic              fi_in_range;
	logic [LINK_W-1:0] link_rd;
	logic [LINK_W-1:0] link_wr;

	// Aligned item size, from the clamped configuration.
	always_comb begin
		if (cfg.align_log2 < ALIGN_LOG2_MIN) begin
			lg = ALIGN_LOG2_MIN;
		end else if (cfg.align_log2 > ALIGN_LOG2_MAX) begin
			lg = ALIGN_LOG2_MAX;
		end else begin
			lg = cfg.align_log2;
		end
		if (cfg.item_size == '0) begin
			sz = SIZE_W'(1);
		end else if (cfg.item_size > ITEM_SIZE_MAX) begin
			sz = ITEM_SIZE_MAX;
		end else begin
			sz = cfg.item_size;
		end
		mask      = ~({SIZE_W{1'b1}} << lg);
		round_sum = {1'b0, sz} + {1'b0, mask};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_q <= ALIGNED_RST;
		end else begin
			aligned_q <= round_sum[SIZE_W-1:0] & ~mask;
		end
	end

	assign fi_in_range = (32'(fi_q) < CAPACITY);
	assign link_wr     = {!nonempty_q, head_q};
	assign link_we     = cmd.commit && (op_q == OP_FREE) && fi_in_range;

	// The link entry of the current head is read every cycle; it is stable
	// from the accept edge on, since only a committed free writes the store.
	fipa_ram #(
		.WIDTH(LINK_W),
		.DEPTH(LINK_DEPTH)
	) u_link (
		.clk  (clk),
		.we   (link_we),
		.waddr(fi_q[AW-1:0]),
		.wdata(link_wr),
		.raddr(head_q[AW-1:0]),
		.rdata(link_rd)
	);

	always_comb begin
		head_d     = head_q;
		nonempty_d = nonempty_q;
		bump_d     = bump_q;
		live_d     = live_q;
		idx        = '0;
		got        = 1'b0;
		exhausted  = 1'b0;
		case (op_q)
			OP_ALLOC: begin
				if (nonempty_q) begin
					idx        = IW'(head_q);
					head_d     = link_rd[IDX_W-1:0];
					nonempty_d = !link_rd[IDX_W];
					got        = 1'b1;
				end else if (bump_q < BW'(CAPACITY)) begin
					idx    = IW'(bump_q);
					bump_d = bump_q + 1'b1;
					got    = 1'b1;
				end else begin
					exhausted = 1'b1;
				end
				if (got && live_q != LIVE_MAX) begin
					live_d = live_q + 1'b1;
				end
			end
			OP_FREE: begin
				if (fi_in_range) begin
					head_d     = fi_q;
					nonempty_d = 1'b1;
					if (live_q != '0) begin
						live_d = live_q - 1'b1;
					end
				end
			end
			OP_RESTART: begin
				head_d     = '0;
				nonempty_d = 1'b0;
				bump_d     = '0;
				live_d     = '0;
			end
			default: ;
		endcase
	end

	assign prod = PW'(idx) * PW'(aligned_q);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= op_t'(operation);
			fi_q <= free_index;
		end
		if (cmd.commit) begin
			item_q   <= IDX_W'(idx);
			offset_q <= OFS_W'(prod);
			status_q <= exhausted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			nonempty_q <= 1'b0;
			bump_q     <= '0;
			live_q     <= '0;
		end else if (cmd.commit) begin
			head_q     <= head_d;
			nonempty_q <= nonempty_d;
			bump_q     <= bump_d;
			live_q     <= live_d;
		end
	end

	assign item_index  = item_q;
	assign byte_offset = offset_q;
	assign status      = status_q;
	assign live_count  = live_q;
	assign high_water  = CNT_W'(bump_q);

	a_bump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= BW'(CAPACITY))
		else $error("bump counter passed the pool capacity");

	a_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == OP_ALLOC && !nonempty_q && bump_q == BW'(CAPACITY))
		|=> (status_q && bump_q == BW'(CAPACITY)))
		else $error("allocation from a full pool did not report exhausted");

	a_free_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == OP_FREE && fi_in_range)
		|=> (nonempty_q && head_q == $past(fi_q)))
		else $error("freed index is not the new free list head");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == OP_RESTART)
		|=> (bump_q == '0 && !nonempty_q && live_q == '0))
		else $error("restart left pool state behind");

endmodule

/* hw/rtl/fixed_item_pool_allocator.sv */
`timescale 1ns / 1ps
// Fixed-size item pool allocator with a LIFO free list.
// The request channel carries one beat per operation: allocate, free the
// given index, or restart the pool. The response channel returns exactly one
// beat per request with the index, its byte offset, a status bit (set when an
// allocation finds the pool exhausted), the live count and the high-water count.
// Each request passes through an accept cycle, in which the link memory is read at
// the current free list head, and then an execute cycle, in which the pop or push
// and the index times aligned size multiply are done and the result is written
// to the output register. No new request is taken during the execute cycle.
// The output register frees the request side: a new request is accepted while
// a finished response still waits. If the receiver stalls, the execute cycle
// waits until the output register empties, and no further request is taken.
// Reset clears the counters and the free list and restores the item size and
// alignment registers to 8 bytes and 8-byte alignment. The link memory is not
// cleared and needs no clearing pass; an entry is only used after a free wrote it.
// The APB port writes the registers; write them only while the block is idle.
module fixed_item_pool_allocator import fipa_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	fipa_req_if.sink           req,
	fipa_rsp_if.source         rsp
);

	cfg_t cfg;
	cmd_t cmd;

	// Configuration registers: item size and alignment.
	fipa_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Sequencer: accept, execute, and the valid flag of the output register.
	fipa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.cmd      (cmd)
	);

	// Free list, bump counter, live count, link memory and offset multiply.
	fipa_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.operation  (req.operation),
		.free_index (req.free_index),
		.item_index (rsp.item_index),
		.byte_offset(rsp.byte_offset),
		.status     (rsp.status),
		.live_count (rsp.live_count),
		.high_water (rsp.high_water)
	);

endmodule

/* tb/fipa_pool_checker.sv */
`timescale 1ns / 1ps
module fipa_pool_checker import fipa_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	fipa_req_if                req,
	fipa_rsp_if                rsp,
	output int                 mismatches,
	output int                 outstanding,
	output int                 replies
);

	typedef struct packed {
		logic [IDX_W-1:0] item_index;
		logic [OFS_W-1:0] byte_offset;
		logic             status;
		logic [CNT_W-1:0] live_count;
		logic [CNT_W-1:0] high_water;
	} alloc_reply_t;

	// Shadow of the pool: the threaded free list, its head, the bump counter
	// and the live count, plus the two configuration registers.
	logic [IDX_W-1:0]  chain_next [CAPACITY];
	logic              chain_end  [CAPACITY];
	logic [IDX_W-1:0]  list_head;
	logic              list_nonempty;
	logic [CNT_W-1:0]  bump_count;
	logic [CNT_W-1:0]  live_total;
	logic [SIZE_W-1:0] size_reg;
	logic [LOG_W-1:0]  log_reg;

	alloc_reply_t awaited_replies [$];
	alloc_reply_t want;
	alloc_reply_t seen;

	// Item size after clamping, rounded up to the clamped alignment.
	function automatic int slot_bytes(input logic [SIZE_W-1:0] size,
		input logic [LOG_W-1:0] lg);
		int sz;
		int shift;
		sz = (size == '0) ? 1 : ((size > ITEM_SIZE_MAX) ? int'(ITEM_SIZE_MAX) : int'(size));
		shift = (lg < ALIGN_LOG2_MIN) ? int'(ALIGN_LOG2_MIN) :
			((lg > ALIGN_LOG2_MAX) ? int'(ALIGN_LOG2_MAX) : int'(lg));
		return ((sz + (1 << shift) - 1) >> shift) << shift;
	endfunction

	task automatic compute_alloc_reply(input logic [OP_W-1:0] op,
		input logic [IDX_W-1:0] fi, output alloc_reply_t r);
		logic [IDX_W-1:0] idx;
		logic             granted;
		int               ofs;
		idx = '0;
		granted = 1'b0;
		ofs = 0;
		r = '0;
		case (op)
			OP_ALLOC: begin
				if (list_nonempty) begin
					idx = list_head;
					list_nonempty = !chain_end[list_head];
					list_head = chain_next[list_head];
					granted = 1'b1;
				end else if (bump_count < CAPACITY) begin
					idx = bump_count[IDX_W-1:0];
					bump_count = bump_count + 1'b1;
					granted = 1'b1;
				end else begin
					r.status = 1'b1;
				end
				if (granted) begin
					if (live_total != LIVE_MAX)
						live_total = live_total + 1'b1;
					ofs = int'(idx) * slot_bytes(size_reg, log_reg);
				end
			end
			OP_FREE: begin
				if (fi < CAPACITY) begin
					chain_next[fi] = list_head;
					chain_end[fi] = !list_nonempty;
					list_head = fi;
					list_nonempty = 1'b1;
					if (live_total != '0)
						live_total = live_total - 1'b1;
				end
			end
			OP_RESTART: begin
				list_head = '0;
				list_nonempty = 1'b0;
				bump_count = '0;
				live_total = '0;
			end
			default: ;
		endcase
		r.item_index = idx;
		r.byte_offset = ofs[OFS_W-1:0];
		r.live_count = live_total;
		r.high_water = bump_count;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg = ITEM_SIZE_RST;
			log_reg = ALIGN_LOG2_RST;
			list_head = '0;
			list_nonempty = 1'b0;
			bump_count = '0;
			live_total = '0;
			awaited_replies.delete();
			mismatches = 0;
			outstanding = 0;
			replies = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_ITEM_SIZE:  size_reg = pwdata[SIZE_W-1:0];
					REG_ALIGN_LOG2: log_reg = pwdata[LOG_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				compute_alloc_reply(req.operation, req.free_index, want);
				awaited_replies.push_back(want);
			end
			if (rsp.valid && rsp.ready) begin
				replies++;
				seen.item_index = rsp.item_index;
				seen.byte_offset = rsp.byte_offset;
				seen.status = rsp.status;
				seen.live_count = rsp.live_count;
				seen.high_water = rsp.high_water;
				if (awaited_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: reply beat %0d arrived with no request pending",
							$realtime, replies);
				end else begin
					want = awaited_replies.pop_front();
					if (seen.item_index !== want.item_index ||
						seen.byte_offset !== want.byte_offset ||
						seen.status !== want.status ||
						seen.live_count !== want.live_count ||
						seen.high_water !== want.high_water) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: reply beat %0d expected/actual: index %0d/%0d ",
								"offset %0d/%0d status %0d/%0d live %0d/%0d high %0d/%0d"},
								$realtime, replies, want.item_index, seen.item_index,
								want.byte_offset, seen.byte_offset, want.status, seen.status,
								want.live_count, seen.live_count,
								want.high_water, seen.high_water);
					end
				end
			end
			outstanding = awaited_replies.size();
		end
	end

endmodule

/* tb/tb_fixed_item_pool_allocator.sv */
`timescale 1ns / 1ps
module tb_fixed_item_pool_allocator;
	import fipa_pkg::*;

	localparam int POOL_CAPACITY = 1024;
	localparam int CYCLE_LIMIT = 1000000;
	// The block decodes operation code 3 as a request that changes nothing.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatches;
	int outstanding;
	int replies;

	// Bookkeeping for the summary and for steering frees toward indices that
	// the pool has actually handed out.
	int n_alloc;
	int n_free;
	int n_restart;
	int n_unused;
	int n_settings;
	int send_quiet;
	int recv_quiet;
	logic [CNT_W-1:0] hw_seen;

	fipa_req_if req_ch ();
	fipa_rsp_if rsp_ch ();

	fixed_item_pool_allocator #(.CAPACITY(POOL_CAPACITY)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// The checker watches both channels and the register port on its own; the
	// top only produces stimulus and reads back its counters for the verdict.
	fipa_pool_checker #(.CAPACITY(POOL_CAPACITY)) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.replies     (replies)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog. It is sized from the slowest legal run: every request waiting
	// out the longest sender gap, the longest receiver stall and the accept and
	// execute steps of the block itself, with a wide margin on top.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Run stopped at the cycle limit with %0d replies still awaited.",
			outstanding);
		$display("[fixed_item_pool_allocator] ERROR");
		$finish;
	end

	// Track the latest high-water count so random frees mostly name indices
	// that were really allocated, which keeps the free list deep and busy.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_seen <= '0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			hw_seen <= rsp_ch.high_water;
		end
	end

	// Draws the number of idle cycles in front of the next beat. Now and then
	// a run of back-to-back beats is started so that the block also sees
	// stretches at full rate on that side.
	function automatic int pick_wait(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0)
			quiet_left = $urandom_range(8, 40);
		return $urandom_range(0, 19);
	endfunction

	// Response side: stall a random number of cycles, then hold ready high
	// until one beat has been taken.
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		recv_quiet = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = pick_wait(recv_quiet);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			@(negedge clk);
		end
	end

	// Presents one request beat and returns at the edge that accepts it. Valid
	// stays high after the accept so that a following beat with no gap goes
	// out without a bubble.
	task automatic send_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] fi);
		int gap;
		gap = pick_wait(send_quiet);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.free_index <= fi;
		case (op)
			OP_ALLOC:   n_alloc++;
			OP_FREE:    n_free++;
			OP_RESTART: n_restart++;
			default:    n_unused++;
		endcase
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Stops sending and waits until every reply the checker expects is back,
	// then a few more cycles in case the block is still settling.
	task automatic drain_replies();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(input reg_idx_t which, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Registers are only touched with the pool idle. Bits above each field
	// carry random junk, which the block must ignore.
	task automatic set_pool_config(input logic [SIZE_W-1:0] size,
		input logic [LOG_W-1:0] lg);
		logic [PDATA_W-1:0] v;
		drain_replies();
		v = $urandom;
		v[SIZE_W-1:0] = size;
		write_reg(REG_ITEM_SIZE, v);
		v = $urandom;
		v[LOG_W-1:0] = lg;
		write_reg(REG_ALIGN_LOG2, v);
		n_settings++;
	endtask

	// Random traffic: mostly allocate and free with frees aimed at handed-out
	// indices, some fully random frees (double and never-allocated frees among
	// them), rare restarts and unused opcodes. Once in a while the sender
	// holds off until the pipeline is empty.
	task automatic run_random(input int n);
		int pick;
		logic [IDX_W-1:0] fi;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (hw_seen != '0 && $urandom_range(0, 4) != 0)
				fi = IDX_W'($urandom_range(0, int'(hw_seen) - 1));
			else
				fi = IDX_W'($urandom_range(0, POOL_CAPACITY - 1));
			if (pick < 55)
				send_req(OP_ALLOC, fi);
			else if (pick < 92)
				send_req(OP_FREE, fi);
			else if (pick < 95)
				send_req(OP_RESTART, fi);
			else
				send_req(OP_UNUSED, fi);
			if ($urandom_range(0, 149) == 0)
				drain_replies();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_ALLOC;
		req_ch.free_index = '0;
		n_alloc = 0;
		n_free = 0;
		n_restart = 0;
		n_unused = 0;
		n_settings = 1;
		send_quiet = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset setting (8-byte items, 8-byte
		// alignment). A free with nothing live must not drive the live count
		// below zero; the freed index then comes straight back.
		send_req(OP_FREE, 10'd0);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_ALLOC, 10'd0);
		// Freeing the top index that was never handed out, then freeing the
		// same index twice, which links that entry to itself.
		send_req(OP_FREE, 10'h3FF);
		send_req(OP_FREE, 10'd1);
		send_req(OP_FREE, 10'd1);
		send_req(OP_ALLOC, 10'h3FF);
		send_req(OP_ALLOC, 10'h3FF);
		send_req(OP_RESTART, 10'h3FF);
		send_req(OP_UNUSED, 10'h3FF);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_FREE, 10'd0);
		send_req(OP_ALLOC, 10'd0);
		// Alternating bit patterns on the free index, popped back in LIFO order
		// before the bump counter takes over again.
		send_req(OP_FREE, 10'h2AA);
		send_req(OP_FREE, 10'h155);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_UNUSED, 10'd0);
		send_req(OP_RESTART, 10'd0);

		// Zero item size and alignment below the minimum both clamp.
		set_pool_config(13'd0, 4'd0);
		run_random(70);

		// Largest item and alignment: fill the whole pool, run into the
		// exhausted case twice, then build a self-linked free entry and pop
		// it several times in a row.
		set_pool_config(ITEM_SIZE_MAX, ALIGN_LOG2_MAX);
		send_req(OP_RESTART, IDX_W'($urandom_range(0, POOL_CAPACITY - 1)));
		repeat (POOL_CAPACITY)
			send_req(OP_ALLOC, IDX_W'($urandom_range(0, POOL_CAPACITY - 1)));
		repeat (2) send_req(OP_ALLOC, IDX_W'($urandom_range(0, POOL_CAPACITY - 1)));
		send_req(OP_FREE, 10'h3FF);
		send_req(OP_FREE, 10'h3FF);
		repeat (8) send_req(OP_ALLOC, IDX_W'($urandom_range(0, POOL_CAPACITY - 1)));
		send_req(OP_FREE, 10'd5);
		send_req(OP_ALLOC, 10'd0);
		send_req(OP_RESTART, 10'd0);

		// Register values above their legal ranges clamp to the maxima.
		set_pool_config(13'h1FFF, 4'hF);
		run_random(70);
		set_pool_config(13'd1, ALIGN_LOG2_MIN);
		run_random(70);
		set_pool_config(ITEM_SIZE_MAX, ALIGN_LOG2_MIN);
		run_random(70);
		set_pool_config(13'd4095, 4'd4);
		run_random(70);
		set_pool_config(SIZE_W'($urandom_range(0, 8191)), LOG_W'($urandom_range(0, 15)));
		run_random(70);
		set_pool_config(SIZE_W'($urandom_range(0, 8191)), LOG_W'($urandom_range(0, 15)));
		run_random(70);

		// Let the last replies come back, then allow some slack before the verdict.
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests: %0d allocate, %0d free, %0d restart, %0d unused code.",
			n_alloc + n_free + n_restart + n_unused, n_alloc, n_free, n_restart, n_unused);
		$display("Checked %0d replies across %0d pool settings, %0d mismatching.",
			replies, n_settings, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("[fixed_item_pool_allocator] OK");
		else
			$display("[fixed_item_pool_allocator] ERROR");
		$finish;
	end

endmodule
